// ===== design/rat_pkg.sv =====
// Shared constants, codes and types of the region address translation table.
`timescale 1ns / 1ps

package rat_pkg;

   // Field widths on the ports
   localparam int OP_BITS   = 2;
   localparam int ST_BITS   = 2;
   localparam int DATA_BITS = 32;
   localparam int LEN_BITS  = 32;
   // Range end sums: address plus length, never wrapping
   localparam int SUM_BITS  = LEN_BITS + 1;

   // Defaults of the top-level parameters
   localparam int DEF_NUM_REGIONS = 16;
   localparam int DEF_ADDR_BITS   = 32;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_REGISTER  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_TRANSLATE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REVERSE   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR     = 2'd3;

   // Status codes
   localparam logic [ST_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [ST_BITS-1:0] ST_CLASH     = 2'd1;
   localparam logic [ST_BITS-1:0] ST_FULL      = 2'd2;
   localparam logic [ST_BITS-1:0] ST_NOT_FOUND = 2'd3;

   // Compare flags of one stored region against the request in flight
   typedef struct packed {
      logic clash;
      logic fwd_hit;
      logic rev_hit;
   } rat_hit_type;

   // One result
   typedef struct packed {
      logic [ST_BITS-1:0]   status;
      logic [DATA_BITS-1:0] phys_out;
      logic [DATA_BITS-1:0] virt_out;
      logic [DATA_BITS-1:0] kern_out;
      logic [DATA_BITS-1:0] offset_out;
   } rat_rsp_type;

endpackage

// ===== design/rat_entry.sv =====
// One stored region: its base and size registers and its range comparators.
`timescale 1ns / 1ps

module rat_entry #(
   parameter int AW = rat_pkg::DEF_ADDR_BITS
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_virt,
   input  logic [AW-1:0]                wr_phys,
   input  logic [AW-1:0]                wr_kern,
   input  logic [rat_pkg::LEN_BITS-1:0] wr_len,
   input  logic [AW-1:0]                lk_virt,
   input  logic [AW-1:0]                lk_phys,
   input  logic [rat_pkg::LEN_BITS-1:0] lk_len,
   output rat_pkg::rat_hit_type         hit,
   output logic [AW-1:0]                fwd_off,
   output logic [AW-1:0]                rev_off,
   output logic [AW-1:0]                virt_base,
   output logic [AW-1:0]                phys_base,
   output logic [AW-1:0]                kern_base
);

   localparam int SW = rat_pkg::SUM_BITS;

   logic [AW-1:0]                virt_ff;
   logic [AW-1:0]                phys_ff;
   logic [AW-1:0]                kern_ff;
   logic [rat_pkg::LEN_BITS-1:0] size_ff;

   logic [SW-1:0] v, vend, rv, rend, p, rp, pend;

   // Region storage, written once when the region is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         virt_ff <= wr_virt;
         phys_ff <= wr_phys;
         kern_ff <= wr_kern;
         size_ff <= wr_len;
      end
   end

   // Range ends as wide sums
   always_comb begin
      v    = SW'(lk_virt);
      vend = SW'(lk_virt) + SW'(lk_len);
      rv   = SW'(virt_ff);
      rend = SW'(virt_ff) + SW'(size_ff);
      p    = SW'(lk_phys);
      rp   = SW'(phys_ff);
      pend = SW'(phys_ff) + SW'(size_ff);
   end

   // Overlap and containment tests
   always_comb begin
      hit.clash   = (v >= rv && vend <= rend)    // region holds request
                 || (rv >= v && rend <= vend)    // request holds region
                 || (v >= rv && v < rend)        // first byte inside
                 || (rv < vend && vend <= rend); // last byte inside
      hit.fwd_hit = (v >= rv) && (v < rend) && (vend <= rend);
      hit.rev_hit = (p >= rp) && (p < pend);
   end

   assign fwd_off   = lk_virt - virt_ff;
   assign rev_off   = lk_phys - phys_ff;
   assign virt_base = virt_ff;
   assign phys_base = phys_ff;
   assign kern_base = kern_ff;

endmodule

// ===== design/rat_select.sv =====
// Picks the newest matching region and forms the result of one request.
`timescale 1ns / 1ps

module rat_select #(
   parameter int NUM_REGIONS = rat_pkg::DEF_NUM_REGIONS,
   parameter int AW          = rat_pkg::DEF_ADDR_BITS,
   parameter int CW          = $clog2(NUM_REGIONS + 1),
   parameter int IW          = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1
) (
   input  logic [rat_pkg::OP_BITS-1:0] op,
   input  logic [CW-1:0]               count,
   input  rat_pkg::rat_hit_type        hits      [NUM_REGIONS],
   input  logic [AW-1:0]               fwd_off   [NUM_REGIONS],
   input  logic [AW-1:0]               rev_off   [NUM_REGIONS],
   input  logic [AW-1:0]               virt_base [NUM_REGIONS],
   input  logic [AW-1:0]               phys_base [NUM_REGIONS],
   input  logic [AW-1:0]               kern_base [NUM_REGIONS],
   output rat_pkg::rat_rsp_type        rsp,
   output logic                        commit
);

   localparam int DW = rat_pkg::DATA_BITS;

   logic          any_clash, full;
   logic          fwd_found, rev_found;
   logic [IW-1:0] fwd_sel, rev_sel;
   logic [AW-1:0] fwd_o, rev_o;

   // Only the first count entries hold regions; the highest index is newest
   always_comb begin
      any_clash = 1'b0;
      fwd_found = 1'b0;
      rev_found = 1'b0;
      fwd_sel   = '0;
      rev_sel   = '0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
         if (CW'(i) < count) begin
            if (hits[i].clash)
               any_clash = 1'b1;
            if (hits[i].fwd_hit) begin
               fwd_found = 1'b1;
               fwd_sel   = IW'(i);
            end
            if (hits[i].rev_hit) begin
               rev_found = 1'b1;
               rev_sel   = IW'(i);
            end
         end
      end
   end

   assign full  = (count >= CW'(NUM_REGIONS));
   assign fwd_o = fwd_off[fwd_sel];
   assign rev_o = rev_off[rev_sel];

   // Result per operation; failures and table updates carry zero data
   always_comb begin
      rsp    = '0;
      commit = 1'b0;
      case (op)
         rat_pkg::OP_REGISTER: begin
            if (full)
               rsp.status = rat_pkg::ST_FULL;
            else if (any_clash)
               rsp.status = rat_pkg::ST_CLASH;
            else begin
               rsp.status = rat_pkg::ST_OK;
               commit     = 1'b1;
            end
         end
         rat_pkg::OP_TRANSLATE: begin
            if (fwd_found) begin
               rsp.status     = rat_pkg::ST_OK;
               rsp.offset_out = DW'(fwd_o);
               rsp.phys_out   = DW'(AW'(phys_base[fwd_sel] + fwd_o));
               rsp.kern_out   = DW'(AW'(kern_base[fwd_sel] + fwd_o));
            end else
               rsp.status = rat_pkg::ST_NOT_FOUND;
         end
         rat_pkg::OP_REVERSE: begin
            if (rev_found) begin
               rsp.status     = rat_pkg::ST_OK;
               rsp.offset_out = DW'(rev_o);
               rsp.virt_out   = DW'(AW'(virt_base[rev_sel] + rev_o));
            end else
               rsp.status = rat_pkg::ST_NOT_FOUND;
         end
         default: begin
            rsp.status = rat_pkg::ST_OK;
         end
      endcase
   end

endmodule

// ===== design/region_address_translation_table.sv =====
// Top level of the region address translation table.
`timescale 1ns / 1ps

// The table holds up to NUM_REGIONS buffer regions (virtual, physical and
// kernel base plus length) and serves four operations chosen by req_tuser:
// register a region (refused on a virtual-range clash or a full table),
// translate a virtual range, reverse-translate a physical address, and clear.
// Every request gives exactly one result on rsp. A request is captured in an
// input register, compared against all stored regions at once in a single
// pass, and its result lands in an output register that drives rsp. A new
// request can be accepted in every cycle while the result side keeps up.
// Table updates take effect for the very next request. Addresses are kept
// modulo 2^ADDR_BITS (at most 32 bits on the ports); no clearing pass runs
// after reset.

module region_address_translation_table #(
   parameter int NUM_REGIONS = rat_pkg::DEF_NUM_REGIONS,
   parameter int ADDR_BITS   = rat_pkg::DEF_ADDR_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // virt_addr[31:0], phys_addr[63:32], kern_addr[95:64], length[127:96]
   input  logic [127:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // phys_out[31:0], virt_out[63:32], kern_out[95:64], offset_out[127:96]
   output logic [127:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int DW = rat_pkg::DATA_BITS;
   localparam int LW = rat_pkg::LEN_BITS;
   localparam int AW = (ADDR_BITS < DW) ? ADDR_BITS : DW;
   localparam int CW = $clog2(NUM_REGIONS + 1);

   // Input stage
   logic                        s_valid_ff, s_valid_in;
   logic [rat_pkg::OP_BITS-1:0] s_op_ff;
   logic [AW-1:0]               s_virt_ff, s_phys_ff, s_kern_ff;
   logic [LW-1:0]               s_len_ff;

   // Result stage and table fill count
   logic                 r_valid_ff, r_valid_in;
   rat_pkg::rat_rsp_type r_rsp_ff;
   logic [CW-1:0]        count_ff, count_in;

   logic req_fire, advance, s_fire, commit;
   rat_pkg::rat_rsp_type rsp_next;

   rat_pkg::rat_hit_type hits      [NUM_REGIONS];
   logic [AW-1:0]        fwd_off   [NUM_REGIONS];
   logic [AW-1:0]        rev_off   [NUM_REGIONS];
   logic [AW-1:0]        virt_base [NUM_REGIONS];
   logic [AW-1:0]        phys_base [NUM_REGIONS];
   logic [AW-1:0]        kern_base [NUM_REGIONS];

   // Handshake: the stage moves on whenever the result register is free
   assign advance    = !r_valid_ff || rsp_tready;
   assign req_tready = !s_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign s_fire     = s_valid_ff && advance;

   assign s_valid_in = req_fire || (s_valid_ff && !advance);
   assign r_valid_in = s_fire || (r_valid_ff && !rsp_tready);

   // Fill count: grows on an accepted registration, drops to zero on clear
   always_comb begin
      count_in = count_ff;
      if (s_fire && commit)
         count_in = count_ff + CW'(1);
      else if (s_fire && s_op_ff == rat_pkg::OP_CLEAR)
         count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         s_valid_ff <= s_valid_in;
         r_valid_ff <= r_valid_in;
         count_ff   <= count_in;
      end
   end

   // Request capture, addresses trimmed to the table width
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s_op_ff   <= req_tuser;
         s_virt_ff <= AW'(req_tdata[31:0]);
         s_phys_ff <= AW'(req_tdata[63:32]);
         s_kern_ff <= AW'(req_tdata[95:64]);
         s_len_ff  <= req_tdata[127:96];
      end
   end

   // Result capture
   always_ff @(posedge clock) begin
      if (s_fire)
         r_rsp_ff <= rsp_next;
   end

   // Region lanes; a registration writes the slot just past the last region
   for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_entry
      rat_entry #(
         .AW(AW)
      ) u_entry (
         .clock     (clock),
         .wr_en     (s_fire && commit && count_ff == CW'(g)),
         .wr_virt   (s_virt_ff),
         .wr_phys   (s_phys_ff),
         .wr_kern   (s_kern_ff),
         .wr_len    (s_len_ff),
         .lk_virt   (s_virt_ff),
         .lk_phys   (s_phys_ff),
         .lk_len    (s_len_ff),
         .hit       (hits[g]),
         .fwd_off   (fwd_off[g]),
         .rev_off   (rev_off[g]),
         .virt_base (virt_base[g]),
         .phys_base (phys_base[g]),
         .kern_base (kern_base[g])
      );
   end

   rat_select #(
      .NUM_REGIONS(NUM_REGIONS),
      .AW         (AW)
   ) u_select (
      .op        (s_op_ff),
      .count     (count_ff),
      .hits      (hits),
      .fwd_off   (fwd_off),
      .rev_off   (rev_off),
      .virt_base (virt_base),
      .phys_base (phys_base),
      .kern_base (kern_base),
      .rsp       (rsp_next),
      .commit    (commit)
   );

   // Output ports
   assign rsp_tvalid = r_valid_ff;
   assign rsp_tuser  = r_rsp_ff.status;
   assign rsp_tdata  = {r_rsp_ff.offset_out, r_rsp_ff.kern_out,
                        r_rsp_ff.virt_out, r_rsp_ff.phys_out};

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_REGIONS))
      else $error("region count beyond table size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (s_fire && s_op_ff == rat_pkg::OP_CLEAR) |=> count_ff == '0)
      else $error("clear left regions in the table");

   a_commit_grows: assert property (@(posedge clock) disable iff (reset)
      (s_fire && commit) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("registration did not add a region");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      (s_fire && s_op_ff == rat_pkg::OP_REGISTER && count_ff == CW'(NUM_REGIONS))
      |=> (rsp_tvalid && rsp_tuser == rat_pkg::ST_FULL && count_ff == $past(count_ff)))
      else $error("registration into a full table not refused");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != rat_pkg::ST_OK) |-> rsp_tdata == '0)
      else $error("failed request carries data");

endmodule

// ===== sim/region_address_translation_table_tb.sv =====
// Self-checking testbench of the region address translation table.
`timescale 1ns / 1ps

module region_address_translation_table_tb;

   localparam int NUM_REGIONS = rat_pkg::DEF_NUM_REGIONS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTS  = 50;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = rat_pkg::OP_TRANSLATE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   // Shadow copy of the region table
   int          tbl_count = 0;
   logic [31:0] tbl_virt [NUM_REGIONS];
   logic [31:0] tbl_phys [NUM_REGIONS];
   logic [31:0] tbl_kern [NUM_REGIONS];
   logic [31:0] tbl_size [NUM_REGIONS];

   rat_pkg::rat_rsp_type pending_responses [$];

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int unsigned req_gap_pct    = 0;
   int unsigned rsp_stall_pct  = 0;
   int          hold_req       = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;

   // Windows the random regions are placed in
   logic [31:0] win_virt = 32'h0001_0000;
   logic [31:0] win_phys = 32'h0002_0000;

   region_address_translation_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Range ends compared as 33-bit sums, so nothing wraps
   function automatic logic end_le(logic [31:0] a, logic [31:0] b,
                                   logic [31:0] c, logic [31:0] d);
      return ({1'b0, a} + {1'b0, b}) <= ({1'b0, c} + {1'b0, d});
   endfunction

   function automatic logic end_lt(logic [31:0] a, logic [31:0] b,
                                   logic [31:0] c, logic [31:0] d);
      return ({1'b0, a} + {1'b0, b}) < ({1'b0, c} + {1'b0, d});
   endfunction

   // New virtual range against stored region idx
   function automatic logic region_clashes(int idx, logic [31:0] v, logic [31:0] n);
      logic [31:0] rv;
      logic [31:0] rn;
      logic        r_holds_t;
      logic        t_holds_r;
      logic        first_in;
      logic        last_in;
      rv = tbl_virt[idx];
      rn = tbl_size[idx];
      r_holds_t = (v >= rv) && end_le(v, n, rv, rn);
      t_holds_r = (rv >= v) && end_le(rv, rn, v, n);
      first_in  = (v >= rv) && end_lt(v, 32'd0, rv, rn);
      last_in   = end_lt(rv, 32'd0, v, n) && end_le(v, n, rv, rn);
      return r_holds_t || t_holds_r || first_in || last_in;
   endfunction

   // Applies one request to the shadow table and returns the result it gives
   function automatic rat_pkg::rat_rsp_type table_response(logic [1:0] op,
                                                           logic [31:0] va,
                                                           logic [31:0] pa,
                                                           logic [31:0] ka,
                                                           logic [31:0] len);
      rat_pkg::rat_rsp_type r;
      logic        found;
      logic [31:0] off;
      r = '0;
      found = 1'b0;
      case (op)
         rat_pkg::OP_REGISTER: begin
            if (tbl_count >= NUM_REGIONS) begin
               r.status = rat_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < tbl_count; i++)
                  if (region_clashes(i, va, len))
                     found = 1'b1;
               if (found) begin
                  r.status = rat_pkg::ST_CLASH;
               end else begin
                  tbl_virt[tbl_count] = va;
                  tbl_phys[tbl_count] = pa;
                  tbl_kern[tbl_count] = ka;
                  tbl_size[tbl_count] = len;
                  tbl_count++;
                  r.status = rat_pkg::ST_OK;
               end
            end
         end
         rat_pkg::OP_TRANSLATE: begin
            r.status = rat_pkg::ST_NOT_FOUND;
            // newest region first
            for (int k = tbl_count - 1; k >= 0; k--) begin
               if (!found && va >= tbl_virt[k] && end_lt(va, 32'd0, tbl_virt[k], tbl_size[k])
                   && end_le(va, len, tbl_virt[k], tbl_size[k])) begin
                  found        = 1'b1;
                  off          = va - tbl_virt[k];
                  r.status     = rat_pkg::ST_OK;
                  r.offset_out = off;
                  r.phys_out   = tbl_phys[k] + off;
                  r.kern_out   = tbl_kern[k] + off;
               end
            end
         end
         rat_pkg::OP_REVERSE: begin
            r.status = rat_pkg::ST_NOT_FOUND;
            for (int k = tbl_count - 1; k >= 0; k--) begin
               if (!found && pa >= tbl_phys[k]
                   && end_lt(pa, 32'd0, tbl_phys[k], tbl_size[k])) begin
                  found        = 1'b1;
                  off          = pa - tbl_phys[k];
                  r.status     = rat_pkg::ST_OK;
                  r.offset_out = off;
                  r.virt_out   = tbl_virt[k] + off;
               end
            end
         end
         default: begin
            tbl_count = 0;
            r.status  = rat_pkg::ST_OK;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // Drives one request, waits for its handshake, then idles at random
   task automatic send_request(input logic [1:0] op, input logic [31:0] va,
                               input logic [31:0] pa, input logic [31:0] ka,
                               input logic [31:0] len);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {len, ka, pa, va};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_responses.push_back(table_response(op, va, pa, ka, len));
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic idle_request();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (pending_responses.size() != 0)
         @(posedge clock);
   endtask

   // Random registrations, clears and lookups, lookups mostly aimed at stored regions, plus noise
   task automatic send_random_item();
      logic [1:0]  op;
      logic [31:0] va;
      logic [31:0] pa;
      logic [31:0] ka;
      logic [31:0] len;
      logic [31:0] off;
      logic [31:0] room;
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(99);
      ka   = $urandom;
      va   = $urandom;
      pa   = $urandom;
      len  = $urandom;
      if (pick < 8) begin
         op = 2'($urandom);
      end else if (pick == 8 || (tbl_count == NUM_REGIONS && $urandom_range(3) == 0)) begin
         op = rat_pkg::OP_CLEAR;
         // fresh windows, often near the top of the address space
         win_virt = ($urandom_range(3) == 0) ? (32'hFFFF_0000 | $urandom_range(16'hFFFF))
                                             : $urandom;
         win_phys = $urandom;
      end else if (pick < 45) begin
         op = rat_pkg::OP_REGISTER;
         va = win_virt + $urandom_range(16'hFFFF);
         pa = win_phys + $urandom_range(16'h3FFF);
         case ($urandom_range(19))
            0:       len = 32'd0;
            1:       len = $urandom;
            default: len = $urandom_range(10'h3FF, 1);
         endcase
      end else if (pick < 75) begin
         op = rat_pkg::OP_TRANSLATE;
         if (tbl_count > 0 && $urandom_range(4) != 0) begin
            k    = $urandom_range(tbl_count - 1);
            off  = $urandom_range(tbl_size[k]);
            va   = tbl_virt[k] + off;
            room = tbl_size[k] - off;
            if (room >= 32'hFFFF_FFF0)
               len = $urandom;
            else if ($urandom_range(1) == 0)
               len = $urandom_range(room + 1);
            else
               len = $urandom_range(16);
         end else begin
            va  = win_virt + $urandom_range(16'hFFFF);
            len = $urandom_range(255);
         end
      end else begin
         op = rat_pkg::OP_REVERSE;
         if (tbl_count > 0 && $urandom_range(4) != 0) begin
            k  = $urandom_range(tbl_count - 1);
            pa = tbl_phys[k] + $urandom_range(tbl_size[k]);
         end else begin
            pa = win_phys + $urandom_range(16'h3FFF);
         end
      end
      send_request(op, va, pa, ka, len);
   endtask

   // Result checker
   always @(posedge clock) begin
      rat_pkg::rat_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("result with none expected", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", {30'd0, rsp_tuser}, {30'd0, want.status});
            if (rsp_tdata[31:0] !== want.phys_out)
               report_mismatch("phys_out", rsp_tdata[31:0], want.phys_out);
            if (rsp_tdata[63:32] !== want.virt_out)
               report_mismatch("virt_out", rsp_tdata[63:32], want.virt_out);
            if (rsp_tdata[95:64] !== want.kern_out)
               report_mismatch("kern_out", rsp_tdata[95:64], want.kern_out);
            if (rsp_tdata[127:96] !== want.offset_out)
               report_mismatch("offset_out", rsp_tdata[127:96], want.offset_out);
         end
      end
   end

   // Result side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("region_address_translation_table_tb: errors");
         $finish;
      end
   end

   // Lookups on an empty table, clash rules, boundaries, newest-wins
   task automatic test_directed();
      send_request(rat_pkg::OP_TRANSLATE, 32'h0000_1000, 32'h0, 32'h0, 32'h1);
      send_request(rat_pkg::OP_REVERSE,   32'h0, 32'h0000_8000, 32'h0, 32'h0);
      send_request(rat_pkg::OP_REGISTER,  32'h0000_1000, 32'h0000_8000, 32'h0000_C000,
                   32'h100);
      // same range, first byte inside, last byte inside, zero length inside
      send_request(rat_pkg::OP_REGISTER,  32'h0000_1000, 32'h1, 32'h2, 32'h100);
      send_request(rat_pkg::OP_REGISTER,  32'h0000_10FF, 32'h1, 32'h2, 32'h10);
      send_request(rat_pkg::OP_REGISTER,  32'h0000_0FF0, 32'h1, 32'h2, 32'h20);
      send_request(rat_pkg::OP_REGISTER,  32'h0000_1080, 32'h1, 32'h2, 32'h0);
      // a zero-length region is accepted, then clashes by containment
      send_request(rat_pkg::OP_REGISTER,  32'h0000_2000, 32'h0009_0000, 32'h3, 32'h0);
      send_request(rat_pkg::OP_REGISTER,  32'h0000_1F00, 32'h1, 32'h2, 32'h200);
      // region ending exactly at 2^32, physically overlapping the first one
      send_request(rat_pkg::OP_REGISTER,  32'hFFFF_FF00, 32'h0000_8080, 32'hFFFF_FFFF,
                   32'h100);
      send_request(rat_pkg::OP_TRANSLATE, 32'h0000_1010, 32'h0, 32'h0, 32'h10);
      send_request(rat_pkg::OP_TRANSLATE, 32'h0000_10F0, 32'h0, 32'h0, 32'h20);
      send_request(rat_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1);
      send_request(rat_pkg::OP_TRANSLATE, 32'h0000_2000, 32'h0, 32'h0, 32'h0);
      send_request(rat_pkg::OP_REVERSE,   32'h0, 32'h0000_80A0, 32'h0, 32'h0);
      send_request(rat_pkg::OP_REVERSE,   32'h0, 32'h0000_8010, 32'h0, 32'h0);
      send_request(rat_pkg::OP_REGISTER,  32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_request(rat_pkg::OP_CLEAR,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      // one region covering every address but the topmost one
      send_request(rat_pkg::OP_REGISTER,  32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_request(rat_pkg::OP_TRANSLATE, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h1);
      send_request(rat_pkg::OP_REVERSE,   32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_request(rat_pkg::OP_REVERSE,   32'h0, 32'hFFFF_FFFE, 32'h0, 32'h0);
      idle_request();
      wait_for_results();
   endtask

   // Fill the table, then full beats clash
   task automatic test_table_full();
      send_request(rat_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < NUM_REGIONS; i++)
         send_request(rat_pkg::OP_REGISTER, 32'h4000_0000 + i * 32'h100, i * 32'h40,
                      ~(32'h4000_0000 + i * 32'h100), 32'h80);
      send_request(rat_pkg::OP_REGISTER, 32'h7000_0000, 32'h0, 32'h0, 32'h10);
      send_request(rat_pkg::OP_REGISTER, 32'h4000_0000, 32'h0, 32'h0, 32'h10);
      send_request(rat_pkg::OP_TRANSLATE, 32'h4000_0F10, 32'h0, 32'h0, 32'h70);
      send_request(rat_pkg::OP_REVERSE, 32'h0, 32'h0000_0050, 32'h0, 32'h0);
      idle_request();
      wait_for_results();
   endtask

   task automatic test_random(input int n, input int unsigned gap_pct,
                              input int unsigned stall_pct);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n; i++)
         send_random_item();
      idle_request();
      wait_for_results();
   endtask

   // Result side held off while requests keep coming; then a full drain
   task automatic test_backpressure();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_req++;
      for (int i = 0; i < 40; i++)
         send_random_item();
      idle_request();
      wait_for_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random(215, 0, 0);
      test_random(215, 83, 0);
      test_random(215, 0, 83);
      test_random(215, 22, 22);
      test_backpressure();
      repeat (10) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch("results left over", pending_responses.size(), 32'd0);
      if (mismatch_count == 0) begin
         $display("region_address_translation_table_tb: clean");
      end else begin
         $display("region_address_translation_table_tb: errors");
      end
      $finish;
   end

endmodule
